[hw/rtl/fbpa_pkg.sv]
package fbpa_pkg;

   localparam int BYTES_W    = 17;
   localparam int TOTAL_W    = 9;
   localparam int POOL_W     = 24;
   localparam int SIZE_W     = 18;
   localparam int IDX_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam logic [POOL_W-1:0]  POOL_MAX    = '1;
   localparam logic [BYTES_W-1:0] BYTES_RESET = 17'd8;
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 9'd256;
   localparam logic [POOL_W-1:0]  POOL_RESET  = 24'd2048;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_EMPTY     = 2'd1,
      STATUS_BAD_INDEX = 2'd2
   } fbpa_status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } fbpa_req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BLOCK_BYTES = 2'd0,
      CSR_BLOCK_TOTAL = 2'd1,
      CSR_POOL_BYTES  = 2'd2
   } fbpa_csr_index_type;

   typedef enum logic [1:0] {
      ST_INIT  = 2'd0,
      ST_IDLE  = 2'd1,
      ST_FETCH = 2'd2
   } fbpa_state_type;

   typedef struct packed {
      logic              busy;
      logic [SIZE_W-1:0] size;
   } fbpa_size_status_type;

endpackage

[hw/rtl/fbpa_if.sv]
interface fbpa_req_if;
   logic                       valid;
   logic                       ready;
   logic                       req_type;
   logic [fbpa_pkg::IDX_W-1:0] block_index;

   modport source (output valid, req_type, block_index, input ready);
   modport sink (input valid, req_type, block_index, output ready);
endinterface

interface fbpa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  status;
   logic [fbpa_pkg::IDX_W-1:0]  given_index;
   logic [fbpa_pkg::POOL_W-1:0] given_offset;
   logic [fbpa_pkg::POOL_W-1:0] free_count;

   modport source (output valid, status, given_index, given_offset, free_count, input ready);
   modport sink (input valid, status, given_index, given_offset, free_count, output ready);
endinterface

interface fbpa_csr_if;
   logic                            valid;
   logic                            ready;
   logic [fbpa_pkg::CSR_IDX_W-1:0]  index;
   logic [fbpa_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/fixed_block_pool_allocator_core.sv]
// Fixed-size block pool with a last-in-first-out free list kept in a one-port-read,
// one-port-write link memory of MAX_BLOCKS entries. A free, and an allocate on an empty
// pool, are registered for output at the transfer; an allocate that gets a block passes
// FETCH first, as the next head is a registered link memory read. Frees go up to one a
// cycle unless the output stalls; an allocate that gets a block holds off requests
// until its response is loaded. After reset and each write to a defined register the
// link memory is rebuilt one entry a cycle while a reciprocal multiply finds the aligned
// block size; no request is taken till both end. Register writes are taken at any time.
module fixed_block_pool_allocator_core #(
   parameter int MAX_BLOCKS = 256,
   parameter int ALIGN      = 8
) (
   input logic         clock,
   input logic         reset,
   fbpa_req_if.sink    req_bus,
   fbpa_rsp_if.source  rsp_bus,
   fbpa_csr_if.sink    csr_bus
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int LW = $clog2(MAX_BLOCKS + 1);
   localparam int CW = (LW > fbpa_pkg::TOTAL_W) ? LW : fbpa_pkg::TOTAL_W;
   localparam int SW = fbpa_pkg::SIZE_W;
   localparam int PW = fbpa_pkg::POOL_W;
   localparam logic [LW-1:0] NULL_LINK = LW'(MAX_BLOCKS);

   logic [fbpa_pkg::BYTES_W-1:0] block_bytes_ff, block_bytes_in;
   logic [fbpa_pkg::TOTAL_W-1:0] block_total_ff, block_total_in;
   logic [PW-1:0]                pool_bytes_ff, pool_bytes_in;
   logic                         restart_ff, restart_in;
   fbpa_pkg::fbpa_state_type     state_ff, state_in;
   logic [LW-1:0]                sweep_ff, sweep_in;
   logic [LW-1:0]                head_ff, head_in;
   logic [PW-1:0]                tally_ff, tally_in;
   logic [LW-1:0]                rd_data_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   fbpa_pkg::fbpa_status_type    status_ff, status_in;
   logic [fbpa_pkg::IDX_W-1:0]   gidx_ff, gidx_in;
   logic [PW-1:0]                goff_ff, goff_in;
   logic [PW-1:0]                fcnt_ff, fcnt_in;

   logic [LW-1:0] link_mem [MAX_BLOCKS];

   fbpa_pkg::fbpa_size_status_type size_status;

   logic          csr_take;
   logic          req_take;
   logic          slot_open;
   logic          req_ready;
   logic          init_done;
   logic          head_null;
   logic [CW-1:0] total_ext;
   logic [CW-1:0] count;
   logic [CW-1:0] idx_ext;
   logic [CW-1:0] head_ext;
   logic          idx_ok;
   logic [CW:0]   sweep_nxt;
   logic [LW-1:0] sweep_link;
   logic [PW-1:0] asz;
   logic [PW:0]   sum_wide;
   logic [PW-1:0] tally_add;
   logic [PW-1:0] tally_sub;
   logic [LW+SW-1:0] prod;
   logic          rd_en;
   logic [IW-1:0] rd_addr;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [LW-1:0] wr_data;
   logic          load_rsp;

   fbpa_align_unit #(
      .ALIGN (ALIGN)
   ) u_fbpa_align_unit (
      .clock       (clock),
      .reset       (reset),
      .start       (restart_ff),
      .block_bytes (block_bytes_ff),
      .size_status (size_status)
   );

   // configuration registers
   assign csr_take      = csr_bus.valid && csr_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_comb begin
      block_bytes_in = block_bytes_ff;
      block_total_in = block_total_ff;
      pool_bytes_in  = pool_bytes_ff;
      restart_in     = 1'b0;
      if (csr_take) begin
         unique case (csr_bus.index)
            fbpa_pkg::CSR_BLOCK_BYTES: begin
               block_bytes_in = csr_bus.data[fbpa_pkg::BYTES_W-1:0];
               restart_in     = 1'b1;
            end
            fbpa_pkg::CSR_BLOCK_TOTAL: begin
               block_total_in = csr_bus.data[fbpa_pkg::TOTAL_W-1:0];
               restart_in     = 1'b1;
            end
            fbpa_pkg::CSR_POOL_BYTES: begin
               pool_bytes_in = csr_bus.data[PW-1:0];
               restart_in    = 1'b1;
            end
            default: restart_in = 1'b0;
         endcase
      end
   end

   // shared datapath terms
   always_comb begin
      total_ext  = CW'(block_total_ff);
      count      = (total_ext > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : total_ext;
      idx_ext    = CW'(req_bus.block_index);
      idx_ok     = idx_ext < count;
      head_ext   = CW'(head_ff);
      head_null  = head_ff == NULL_LINK;
      sweep_nxt  = (CW+1)'(sweep_ff) + (CW+1)'(1);
      sweep_link = (sweep_nxt < {1'b0, count}) ? sweep_nxt[LW-1:0] : NULL_LINK;
      asz        = PW'(size_status.size);
      sum_wide   = {1'b0, tally_ff} + {1'b0, asz};
      tally_add  = sum_wide[PW] ? fbpa_pkg::POOL_MAX : sum_wide[PW-1:0];
      tally_sub  = (tally_ff > asz) ? (tally_ff - asz) : '0;
      prod       = head_ff * size_status.size;
   end

   assign slot_open = !rsp_valid_ff || rsp_bus.ready;
   assign req_ready = (state_ff == fbpa_pkg::ST_IDLE) && !restart_ff && slot_open;
   assign req_take  = req_bus.valid && req_ready;
   assign init_done = (state_ff == fbpa_pkg::ST_INIT) && !restart_ff &&
                      (sweep_ff == NULL_LINK) && !size_status.busy;
   assign req_bus.ready = req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      priority if (restart_ff) begin
         state_in = fbpa_pkg::ST_INIT;
      end else begin
         unique case (state_ff)
            fbpa_pkg::ST_INIT: if (init_done) state_in = fbpa_pkg::ST_IDLE;
            fbpa_pkg::ST_IDLE: begin
               if (req_take && req_bus.req_type == fbpa_pkg::REQ_ALLOC && !head_null)
                  state_in = fbpa_pkg::ST_FETCH;
            end
            fbpa_pkg::ST_FETCH: if (slot_open) state_in = fbpa_pkg::ST_IDLE;
            default: state_in = fbpa_pkg::ST_INIT;
         endcase
      end
   end

   // state machine outputs and list updates
   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = head_ff[IW-1:0];
      wr_en     = 1'b0;
      wr_addr   = sweep_ff[IW-1:0];
      wr_data   = sweep_link;
      sweep_in  = sweep_ff;
      head_in   = head_ff;
      tally_in  = tally_ff;
      load_rsp  = 1'b0;
      status_in = fbpa_pkg::STATUS_OK;
      gidx_in   = '0;
      goff_in   = '0;
      fcnt_in   = tally_ff;
      if (restart_ff) sweep_in = '0;
      unique case (state_ff)
         fbpa_pkg::ST_INIT: begin
            if (!restart_ff && sweep_ff != NULL_LINK) begin
               wr_en    = 1'b1;
               sweep_in = sweep_ff + LW'(1);
            end
            if (init_done) begin
               head_in  = (count == '0) ? NULL_LINK : '0;
               tally_in = pool_bytes_ff;
            end
         end
         fbpa_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_bus.req_type == fbpa_pkg::REQ_ALLOC) begin
                  if (head_null) begin
                     load_rsp  = 1'b1;
                     status_in = fbpa_pkg::STATUS_EMPTY;
                  end else begin
                     rd_en = 1'b1;
                  end
               end else if (idx_ok) begin
                  wr_en    = 1'b1;
                  wr_addr  = idx_ext[IW-1:0];
                  wr_data  = head_ff;
                  head_in  = idx_ext[LW-1:0];
                  tally_in = tally_add;
                  load_rsp = 1'b1;
                  fcnt_in  = tally_add;
               end else begin
                  load_rsp  = 1'b1;
                  status_in = fbpa_pkg::STATUS_BAD_INDEX;
               end
            end
         end
         fbpa_pkg::ST_FETCH: begin
            if (slot_open) begin
               load_rsp = 1'b1;
               gidx_in  = head_ext[fbpa_pkg::IDX_W-1:0];
               goff_in  = PW'(prod);
               tally_in = tally_sub;
               fcnt_in  = tally_sub;
               head_in  = rd_data_ff;
            end
         end
         default: load_rsp = 1'b0;
      endcase
   end

   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_bus.ready);

   // link memory
   always_ff @(posedge clock) begin
      if (wr_en) link_mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_bytes_ff <= fbpa_pkg::BYTES_RESET;
         block_total_ff <= fbpa_pkg::TOTAL_RESET;
         pool_bytes_ff  <= fbpa_pkg::POOL_RESET;
         restart_ff     <= 1'b1;
         state_ff       <= fbpa_pkg::ST_INIT;
         sweep_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         block_bytes_ff <= block_bytes_in;
         block_total_ff <= block_total_in;
         pool_bytes_ff  <= pool_bytes_in;
         restart_ff     <= restart_in;
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      head_ff  <= head_in;
      tally_ff <= tally_in;
      if (load_rsp) begin
         status_ff <= status_in;
         gidx_ff   <= gidx_in;
         goff_ff   <= goff_in;
         fcnt_ff   <= fcnt_in;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = status_ff;
   assign rsp_bus.given_index  = gidx_ff;
   assign rsp_bus.given_offset = goff_ff;
   assign rsp_bus.free_count   = fcnt_ff;

endmodule

[hw/rtl/fbpa_align_unit.sv]
module fbpa_align_unit #(
   parameter int ALIGN = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [fbpa_pkg::BYTES_W-1:0]   block_bytes,
   output fbpa_pkg::fbpa_size_status_type size_status
);

   localparam int SW    = fbpa_pkg::SIZE_W;
   localparam int SHIFT = SW + $clog2(ALIGN);
   localparam int MW    = SW + 1;
   localparam logic [MW-1:0] RECIP =
      MW'(((64'd1 << SHIFT) + 64'(ALIGN) - 64'd1) / 64'(ALIGN));

   logic             busy_ff, busy_in;
   logic             phase_ff, phase_in;
   logic [SW-1:0]    work_ff, work_in;
   logic [SW-1:0]    quot_ff, quot_in;
   logic [SW-1:0]    size_ff, size_in;
   logic [SW+MW-1:0] prod;
   logic [SW-1:0]    rounded;

   // reciprocal multiply gives the exact quotient for every 18-bit size
   always_comb begin
      rounded  = SW'(block_bytes) + SW'(ALIGN - 1);
      prod     = work_ff * RECIP;
      busy_in  = busy_ff;
      phase_in = phase_ff;
      work_in  = work_ff;
      quot_in  = quot_ff;
      size_in  = size_ff;
      if (start) begin
         busy_in  = 1'b1;
         phase_in = 1'b0;
         work_in  = rounded;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            quot_in  = SW'(prod >> SHIFT);
            phase_in = 1'b1;
         end else begin
            size_in = quot_ff * SW'(ALIGN);
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
      work_ff <= work_in;
      quot_ff <= quot_in;
      size_ff <= size_in;
   end

   assign size_status.busy = busy_ff;
   assign size_status.size = size_ff;

endmodule

[hw/rtl/fbpa_checker.sv]
module fbpa_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [1:0]                      rsp_status,
   input logic [fbpa_pkg::IDX_W-1:0]      rsp_given_index,
   input logic [fbpa_pkg::POOL_W-1:0]     rsp_given_offset,
   input logic [fbpa_pkg::POOL_W-1:0]     rsp_free_count,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [fbpa_pkg::CSR_IDX_W-1:0]  csr_index
);

   // a stalled response keeps its content
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_given_index) && $stable(rsp_given_offset) && $stable(rsp_free_count))
      else $error("stalled response changed");

   // errors carry no block
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fbpa_pkg::STATUS_OK |->
         rsp_given_index == '0 && rsp_given_offset == '0)
      else $error("error response carries a block");

   // a new response follows a request transfer, directly or through the fetch state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 1) || $past(req_valid && req_ready, 2))
      else $error("response without a request");

   // a write to a defined register starts a rebuild that holds off requests
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == fbpa_pkg::CSR_BLOCK_BYTES ||
         csr_index == fbpa_pkg::CSR_BLOCK_TOTAL || csr_index == fbpa_pkg::CSR_POOL_BYTES)
      |=> !req_ready)
      else $error("request taken during rebuild");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_bus.valid),
   .req_ready        (req_bus.ready),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_status       (rsp_bus.status),
   .rsp_given_index  (rsp_bus.given_index),
   .rsp_given_offset (rsp_bus.given_offset),
   .rsp_free_count   (rsp_bus.free_count),
   .csr_valid        (csr_bus.valid),
   .csr_ready        (csr_bus.ready),
   .csr_index        (csr_bus.index)
);
